// ----- rtl/core/mse_pkg.sv -----
// types and constants shared by the merge sort engine and its channel interfaces
// depends on nothing
`default_nettype none

package mse_pkg;

	localparam int DEPTH       = 64;
	localparam int DATA_WIDTH  = 32;
	localparam int CMP_W       = 9;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int STACK_DEPTH = $clog2(DEPTH) + 1;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int SIDX_W      = $clog2(STACK_DEPTH);

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic [CMP_W-1:0]             cmp_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	// progress of one split range on the range stack
	typedef enum logic [1:0] {
		PH_LEFT  = 2'd0,
		PH_RIGHT = 2'd1,
		PH_MERGE = 2'd2
	} phase_t;

	typedef struct packed {
		idx_t   lo;
		idx_t   hi;
		phase_t phase;
	} frame_t;

endpackage

`default_nettype wire

// ----- rtl/core/mse_in_if.sv -----
// input channel of the merge sort engine: valid/ready plus one element word
// depends on mse_pkg
`default_nettype none

interface mse_in_if;
	import mse_pkg::*;

	logic  valid;
	logic  ready;
	data_t value;
	logic  last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);

endinterface

`default_nettype wire

// ----- rtl/core/mse_out_if.sv -----
// output channel of the merge sort engine: valid/ready plus one sorted word
// depends on mse_pkg
`default_nettype none

interface mse_out_if;
	import mse_pkg::*;

	logic  valid;
	logic  ready;
	data_t sorted_value;
	logic  last_out;
	cmp_t  comparisons;
	logic  overflow;

	modport source (output valid, output sorted_value, output last_out,
		output comparisons, output overflow, input ready);
	modport sink   (input valid, input sorted_value, input last_out,
		input comparisons, input overflow, output ready);

endinterface

`default_nettype wire

// ----- rtl/core/merge_sort_engine.sv -----
// merge sort engine top level: element store, scratch memory, range stack and sequencer
// depends on mse_pkg, mse_in_if, mse_out_if
`default_nettype none

// Batch sorter. Words are loaded one per cycle into the element store until a word
// marked last; words past DEPTH are dropped and flag overflow on that batch. The batch
// is then sorted ascending (signed) by top-down merge sort, split at lo+(hi-lo)/2, ties
// taking the left element, and emitted in order with last_out on the final word; every
// output word carries the count of merge comparisons for the batch. A batch is loaded, then
// every merged range gets a setup step, a merge (one element a cycle through the two read
// ports of the element store into scratch) and a copy-back from scratch to the store, and
// every split range gets its range-stack steps; each memory has a single write port. In the
// emit phase each word is read from the store, then loaded into the output register, and
// waits there if the sink stalls. The input is ready only while loading; the output
// register lets the last word wait while the next batch is already loading.
module merge_sort_engine (
	input  logic clk,
	input  logic arst_n,
	mse_in_if.sink   in_ch,
	mse_out_if.source out_ch
);
	import mse_pkg::*;

	typedef enum logic [6:0] {
		S_LOAD    = 7'b0000001,
		S_FRAME   = 7'b0000010,
		S_MINIT   = 7'b0000100,
		S_MERGE   = 7'b0001000,
		S_COPY    = 7'b0010000,
		S_EMIT_RD = 7'b0100000,
		S_EMIT_LD = 7'b1000000
	} state_t;

	state_t state_q;

	// batch bookkeeping
	cnt_t   cnt_q;
	cmp_t   cmp_q;
	logic   drop_q;

	// range stack: one frame per recursion level
	frame_t stack_q [STACK_DEPTH];
	logic [SP_W-1:0] sp_q;

	// merge and copy-back loop state
	idx_t   lo_q, mid_q, hi_q;
	cnt_t   i_q, j_q, k_q;
	idx_t   c_q;
	cnt_t   o_q;
	logic   cp_vld_s1;
	idx_t   cp_addr_s1;

	// memories and their registered read data
	data_t  store_mem [DEPTH];
	data_t  scr_mem [DEPTH];
	data_t  rd_a_q, rd_b_q, scr_rd_q;

	// output register
	logic   out_vld_q;
	data_t  out_val_q;
	logic   out_last_q;
	cmp_t   out_cmp_q;
	logic   out_ovf_q;

	// combinational helpers
	logic   in_acc;
	cnt_t   cnt_nxt;
	logic [SIDX_W-1:0] top_idx, push_idx;
	frame_t top;
	idx_t   top_mid;
	logic   left_push, right_push;
	logic   i_ok, j_ok, both_ok, take_left, merge_done, o_last;
	cnt_t   i_nxt, j_nxt;
	data_t  mrg_data;
	idx_t   rd_a_addr, rd_b_addr;
	logic   st_we;
	idx_t   st_waddr;
	data_t  st_wdata;

	assign in_ch.ready = (state_q == S_LOAD);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign cnt_nxt     = (cnt_q < cnt_t'(DEPTH)) ? cnt_q + cnt_t'(1) : cnt_q;

	// top of the range stack and its split point
	assign top_idx    = SIDX_W'(sp_q - SP_W'(1));
	assign push_idx   = SIDX_W'(sp_q);
	assign top        = stack_q[top_idx];
	assign top_mid    = top.lo + ((top.hi - top.lo) >> 1);
	// single-element halves are already sorted, no frame for them
	assign left_push  = (top.lo != top_mid);
	assign right_push = ((top_mid + idx_t'(1)) != top.hi);

	// merge step: heads of both runs sit in the store read registers
	assign i_ok       = (i_q <= cnt_t'(mid_q));
	assign j_ok       = (j_q <= cnt_t'(hi_q));
	assign both_ok    = i_ok && j_ok;
	assign take_left  = both_ok ? (rd_a_q <= rd_b_q) : i_ok;
	assign i_nxt      = i_q + cnt_t'(take_left);
	assign j_nxt      = j_q + cnt_t'(!take_left);
	assign mrg_data   = take_left ? rd_a_q : rd_b_q;
	assign merge_done = (k_q == cnt_t'(hi_q));
	assign o_last     = (o_q == cnt_q - cnt_t'(1));

	// store read addresses: next heads are fetched while this step is decided
	always_comb begin
		rd_a_addr = '0;
		rd_b_addr = '0;
		case (state_q)
			S_MINIT: begin
				rd_a_addr = lo_q;
				rd_b_addr = mid_q + idx_t'(1);
			end
			S_MERGE: begin
				rd_a_addr = i_nxt[IDX_W-1:0];
				rd_b_addr = j_nxt[IDX_W-1:0];
			end
			S_EMIT_RD: begin
				rd_a_addr = o_q[IDX_W-1:0];
			end
			default: begin
				rd_a_addr = '0;
				rd_b_addr = '0;
			end
		endcase
	end

	// store writes: loading, or copy-back in the cycle after the scratch read
	assign st_we    = (in_acc && (cnt_q < cnt_t'(DEPTH))) || cp_vld_s1;
	assign st_waddr = cp_vld_s1 ? cp_addr_s1 : cnt_q[IDX_W-1:0];
	assign st_wdata = cp_vld_s1 ? scr_rd_q : in_ch.value;

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_waddr] <= st_wdata;
		end
		rd_a_q <= store_mem[rd_a_addr];
		rd_b_q <= store_mem[rd_b_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MERGE) begin
			scr_mem[k_q[IDX_W-1:0]] <= mrg_data;
		end
		scr_rd_q <= scr_mem[c_q];
	end

	// sequencer and batch control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			cnt_q     <= '0;
			cmp_q     <= '0;
			drop_q    <= 1'b0;
			sp_q      <= '0;
			cp_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			cp_vld_s1 <= (state_q == S_COPY);
			if (out_ch.valid && out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						cnt_q <= cnt_nxt;
						if (cnt_q == cnt_t'(DEPTH)) begin
							drop_q <= 1'b1;
						end
						if (in_ch.last) begin
							// whole range goes on the stack unless it is one word
							sp_q    <= (cnt_nxt > cnt_t'(1)) ? SP_W'(1) : SP_W'(0);
							state_q <= S_FRAME;
						end
					end
				end
				S_FRAME: begin
					if (sp_q == '0) begin
						state_q <= S_EMIT_RD;
					end else begin
						case (top.phase)
							PH_LEFT: begin
								if (left_push) begin
									sp_q <= sp_q + SP_W'(1);
								end
							end
							PH_RIGHT: begin
								if (right_push) begin
									sp_q <= sp_q + SP_W'(1);
								end
							end
							PH_MERGE: begin
								sp_q    <= sp_q - SP_W'(1);
								state_q <= S_MINIT;
							end
							default: begin
								sp_q <= sp_q;
							end
						endcase
					end
				end
				S_MINIT: begin
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					if (both_ok) begin
						cmp_q <= cmp_q + cmp_t'(1);
					end
					if (merge_done) begin
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					if (c_q == hi_q) begin
						state_q <= S_FRAME;
					end
				end
				S_EMIT_RD: begin
					// read only when the output register is free by next cycle
					if (!out_vld_q || out_ch.ready) begin
						state_q <= S_EMIT_LD;
					end
				end
				S_EMIT_LD: begin
					out_vld_q <= 1'b1;
					if (o_last) begin
						cnt_q   <= '0;
						cmp_q   <= '0;
						drop_q  <= 1'b0;
						state_q <= S_LOAD;
					end else begin
						state_q <= S_EMIT_RD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// loop counters, range stack contents and output payload
	always_ff @(posedge clk) begin
		cp_addr_s1 <= c_q;
		case (state_q)
			S_LOAD: begin
				if (in_acc && in_ch.last) begin
					stack_q[0] <= '{lo: '0, hi: idx_t'(cnt_nxt - cnt_t'(1)), phase: PH_LEFT};
				end
			end
			S_FRAME: begin
				if (sp_q == '0) begin
					o_q <= '0;
				end else begin
					case (top.phase)
						PH_LEFT: begin
							stack_q[top_idx].phase <= PH_RIGHT;
							if (left_push) begin
								stack_q[push_idx] <= '{lo: top.lo, hi: top_mid, phase: PH_LEFT};
							end
						end
						PH_RIGHT: begin
							stack_q[top_idx].phase <= PH_MERGE;
							if (right_push) begin
								stack_q[push_idx] <= '{lo: top_mid + idx_t'(1), hi: top.hi,
									phase: PH_LEFT};
							end
						end
						PH_MERGE: begin
							lo_q  <= top.lo;
							mid_q <= top_mid;
							hi_q  <= top.hi;
						end
						default: begin
							lo_q <= lo_q;
						end
					endcase
				end
			end
			S_MINIT: begin
				i_q <= cnt_t'(lo_q);
				j_q <= cnt_t'(mid_q) + cnt_t'(1);
				k_q <= cnt_t'(lo_q);
			end
			S_MERGE: begin
				i_q <= i_nxt;
				j_q <= j_nxt;
				k_q <= k_q + cnt_t'(1);
				if (merge_done) begin
					c_q <= lo_q;
				end
			end
			S_COPY: begin
				c_q <= c_q + idx_t'(1);
			end
			S_EMIT_LD: begin
				out_val_q  <= rd_a_q;
				out_last_q <= o_last;
				out_cmp_q  <= cmp_q;
				out_ovf_q  <= drop_q;
				o_q        <= o_q + cnt_t'(1);
			end
			default: begin
				o_q <= o_q;
			end
		endcase
	end

	assign out_ch.valid        = out_vld_q;
	assign out_ch.sorted_value = out_val_q;
	assign out_ch.last_out     = out_last_q;
	assign out_ch.comparisons  = out_cmp_q;
	assign out_ch.overflow     = out_ovf_q;

`ifndef SYNTHESIS
	// range stack never runs past its recursion depth
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("range stack overflow");

	// a merge step always has at least one run left
	a_merge_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MERGE |-> (i_ok || j_ok))
		else $error("merge step with both runs exhausted");

	// the scratch write pointer stays inside the merged range
	a_merge_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MERGE |-> (k_q >= cnt_t'(lo_q) && k_q <= cnt_t'(hi_q)))
		else $error("merge write outside range");

	// an output word is loaded only into an empty output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT_LD |-> !out_vld_q)
		else $error("output register overwritten");

	// the element count never exceeds the store depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cnt_t'(DEPTH))
		else $error("element count past depth");
`endif

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// self-checking bench for merge_sort_engine: batches of signed words in, sorted words out
// depends on mse_pkg, mse_in_if, mse_out_if and the merge_sort_engine rtl
`timescale 1ns / 100ps

module tb;
	import mse_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 2000;
	localparam int DRAIN_CYCLES = 64;

	typedef struct {
		data_t value;
		logic  last;
	} load_word_t;

	typedef struct {
		data_t value;
		logic  last_out;
		cmp_t  comparisons;
		logic  overflow;
	} sorted_word_t;

	logic clk;
	logic arst_n;

	mse_in_if  in_ch ();
	mse_out_if out_ch ();

	merge_sort_engine uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// words waiting to be offered, and the sorted words the block still owes us
	load_word_t   pending_words[$];
	sorted_word_t sorted_expect_q[$];

	// predictor copy of the element store for the batch being loaded
	data_t batch_store[DEPTH];
	data_t merge_buf[DEPTH];
	int    batch_count;
	bit    batch_dropped;

	int total_words;
	int issued_words;
	int idle_phase;
	int error_count;
	int checked_words;
	int batches_done;
	int overflow_batches;
	int largest_batch;
	int cycle_count;
	int hold_left;
	bit hold_done;

	// idle share in percent for each stretch of the run
	function automatic int idle_percent(input int phase, input bit receiver);
		case (phase)
			0:       return receiver ? 88 : 22;
			1:       return receiver ? 22 : 88;
			default: return 0;
		endcase
	endfunction

	// top-down merge sort of the loaded batch with an explicit range stack, counting
	// every comparison in the merge loops, then queue one expected word per element
	function automatic void merge_sort_batch();
		int     lo_stk[8];
		int     hi_stk[8];
		phase_t ph_stk[8];
		int     sp;
		int     lo, hi, mid, i, j, k;
		int     cmp_total;
		sorted_word_t w;

		cmp_total = 0;
		if (batch_count > 1) begin
			sp = 1;
			lo_stk[0] = 0;
			hi_stk[0] = batch_count - 1;
			ph_stk[0] = PH_LEFT;
			while (sp > 0) begin
				lo = lo_stk[sp-1];
				hi = hi_stk[sp-1];
				mid = lo + (hi - lo) / 2;
				if (lo >= hi) begin
					sp--;
				end else if (ph_stk[sp-1] == PH_LEFT) begin
					ph_stk[sp-1] = PH_RIGHT;
					lo_stk[sp] = lo;
					hi_stk[sp] = mid;
					ph_stk[sp] = PH_LEFT;
					sp++;
				end else if (ph_stk[sp-1] == PH_RIGHT) begin
					ph_stk[sp-1] = PH_MERGE;
					lo_stk[sp] = mid + 1;
					hi_stk[sp] = hi;
					ph_stk[sp] = PH_LEFT;
					sp++;
				end else begin
					// ties go to the left half
					i = lo;
					j = mid + 1;
					k = lo;
					while (i <= mid && j <= hi) begin
						cmp_total++;
						if (batch_store[i] <= batch_store[j]) begin
							merge_buf[k] = batch_store[i];
							i++;
						end else begin
							merge_buf[k] = batch_store[j];
							j++;
						end
						k++;
					end
					while (i <= mid) begin
						merge_buf[k] = batch_store[i];
						i++;
						k++;
					end
					while (j <= hi) begin
						merge_buf[k] = batch_store[j];
						j++;
						k++;
					end
					for (k = lo; k <= hi; k++)
						batch_store[k] = merge_buf[k];
					sp--;
				end
			end
		end

		for (k = 0; k < batch_count; k++) begin
			w.value       = batch_store[k];
			w.last_out    = (k == batch_count - 1);
			w.comparisons = cmp_t'(cmp_total);
			w.overflow    = batch_dropped;
			sorted_expect_q.push_back(w);
		end
	endfunction

	task automatic add_word(input data_t v, input logic l);
		load_word_t lw;
		lw.value = v;
		lw.last  = l;
		pending_words.push_back(lw);
	endtask

	// one batch of n words with mixed content: full range, a narrow band for ties,
	// and the extremes of the signed range
	task automatic add_random_batch(input int n);
		data_t v;
		int    idx;
		for (idx = 0; idx < n; idx++) begin
			case ($urandom_range(9))
				5, 6:    v = data_t'($signed($urandom_range(15)) - 8);
				7: begin
					case ($urandom_range(3))
						0:       v = {1'b0, {(DATA_WIDTH-1){1'b1}}};
						1:       v = {1'b1, {(DATA_WIDTH-1){1'b0}}};
						2:       v = '0;
						default: v = '1;
					endcase
				end
				default: v = data_t'($urandom);
			endcase
			add_word(v, idx == n - 1);
		end
	endtask

	// clock and the single reset pulse
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// stimulus and end of run
	initial begin
		int rand_words;
		int big_step;
		int size;

		// one word alone, no merge at all
		add_word({1'b1, {(DATA_WIDTH-1){1'b0}}}, 1'b1);
		// two extremes in the wrong order
		add_word({1'b0, {(DATA_WIDTH-1){1'b1}}}, 1'b0);
		add_word({1'b1, {(DATA_WIDTH-1){1'b0}}}, 1'b1);
		// equal words mixed with others
		add_word(data_t'(5), 1'b0);
		add_word(data_t'(5), 1'b0);
		add_word(data_t'(-1), 1'b0);
		add_word(data_t'(5), 1'b1);
		// already ascending across the sign boundary
		add_word(data_t'(-3), 1'b0);
		add_word('1, 1'b0);
		add_word('0, 1'b0);
		add_word(data_t'(2), 1'b1);
		// strictly descending from the top of the range, odd count
		add_word({1'b0, {(DATA_WIDTH-1){1'b1}}}, 1'b0);
		add_word(data_t'(32'h4000_0000), 1'b0);
		add_word('0, 1'b0);
		add_word(data_t'(32'hc000_0000), 1'b0);
		add_word({1'b1, {(DATA_WIDTH-1){1'b0}}}, 1'b1);
		// all equal
		add_word(data_t'(32'h5a5a_a5a5), 1'b0);
		add_word(data_t'(32'h5a5a_a5a5), 1'b0);
		add_word(data_t'(32'h5a5a_a5a5), 1'b1);

		// random batches, mostly short; one batch overruns the store by one to
		// three words, so it fills the store completely and drops the rest
		rand_words = 0;
		big_step = 0;
		while (rand_words < 36) begin
			if (big_step == 0 && rand_words >= 12) begin
				add_random_batch($urandom_range(DEPTH + 3, DEPTH + 1));
				big_step = 1;
			end else begin
				if ($urandom_range(7) == 0)
					size = $urandom_range(24, 13);
				else
					size = $urandom_range(12, 1);
				add_random_batch(size);
				rand_words += size;
			end
		end
		total_words = pending_words.size();

		@(posedge arst_n);
		while (pending_words.size() != 0 || in_ch.valid)
			@(posedge clk);
		while (sorted_expect_q.size() != 0)
			@(posedge clk);
		// anything arriving now is a word nobody asked for
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d batches sorted (%0d with dropped words, up to %0d words loaded)",
			batches_done, overflow_batches, largest_batch);
		$display("%0d sorted words checked, %0d errors", checked_words, error_count);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// input driver: offers queued words, idles at random, and feeds the predictor
	// with every accepted word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.value <= '0;
			in_ch.last  <= 1'b0;
			idle_phase  <= 0;
			issued_words = 0;
			batch_count = 0;
			batch_dropped = 1'b0;
			batches_done = 0;
			overflow_batches = 0;
			largest_batch = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				if (batch_count < DEPTH) begin
					batch_store[batch_count] = in_ch.value;
					batch_count++;
				end else begin
					batch_dropped = 1'b1;
				end
				if (in_ch.last) begin
					merge_sort_batch();
					batches_done++;
					if (batch_dropped)
						overflow_batches++;
					if (batch_count > largest_batch)
						largest_batch = batch_count;
					batch_count = 0;
					batch_dropped = 1'b0;
				end
			end

			// slot is free once the word on the bus is taken or nothing is offered
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_words.size() != 0 &&
					$urandom_range(99) >= idle_percent(idle_phase, 1'b0)) begin
					in_ch.valid <= 1'b1;
					in_ch.value <= pending_words[0].value;
					in_ch.last  <= pending_words[0].last;
					void'(pending_words.pop_front());
					issued_words++;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end

			// three stretches of the run by share of words offered
			if (issued_words * 3 < total_words)
				idle_phase <= 0;
			else if (issued_words * 3 < total_words * 2)
				idle_phase <= 1;
			else
				idle_phase <= 2;
		end
	end

	// output monitor: checks each sorted word against the oldest expectation;
	// at the start of the last stretch it holds ready low long enough for the
	// block to fill and push back on its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
			error_count = 0;
			checked_words = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (sorted_expect_q.size() == 0) begin
					$error("sorted word %0d arrived with none expected", out_ch.sorted_value);
					error_count++;
				end else begin
					if (out_ch.sorted_value !== sorted_expect_q[0].value) begin
						$error("sorted_value: expected %0d, got %0d",
							sorted_expect_q[0].value, out_ch.sorted_value);
						error_count++;
					end
					if (out_ch.last_out !== sorted_expect_q[0].last_out) begin
						$error("last_out: expected %0b, got %0b",
							sorted_expect_q[0].last_out, out_ch.last_out);
						error_count++;
					end
					if (out_ch.comparisons !== sorted_expect_q[0].comparisons) begin
						$error("comparisons: expected %0d, got %0d",
							sorted_expect_q[0].comparisons, out_ch.comparisons);
						error_count++;
					end
					if (out_ch.overflow !== sorted_expect_q[0].overflow) begin
						$error("overflow: expected %0b, got %0b",
							sorted_expect_q[0].overflow, out_ch.overflow);
						error_count++;
					end
					void'(sorted_expect_q.pop_front());
					checked_words++;
				end
			end

			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else if (idle_phase == 2 && !hold_done) begin
				out_ch.ready <= 1'b0;
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= idle_percent(idle_phase, 1'b1));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycle_count, sorted_expect_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial cycle_count = 0;

endmodule
